>>> design/xlg_pkg.sv
// Shared constants, types and state encoding of the xoshiro256++ lane generator.
`default_nettype none
package xlg_pkg;

	localparam int unsigned LANE_COUNT_DEF = 16;

	localparam int unsigned WORD_W     = 64;
	localparam int unsigned HALF_W     = 32;
	localparam int unsigned FRAC_W     = 54;
	localparam int unsigned LANE_IN_W  = 4;
	localparam int unsigned LANE_SPAN  = 2 ** LANE_IN_W;
	localparam int unsigned TRAJ_IN_W  = 35;
	localparam int unsigned TRAJ_INC_W = TRAJ_IN_W + 1;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = 2;

	localparam logic [WORD_W-1:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [WORD_W-1:0] MIX_MUL_ONE  = 64'hBF58_476D_1CE4_E5B9;
	localparam logic [WORD_W-1:0] MIX_MUL_TWO  = 64'h94D0_49BB_1331_11EB;
	localparam logic [WORD_W-1:0] TRAJ_MUL     = 64'hD2B7_4407_B1CE_6E93;

	localparam int unsigned MIX_SH_ONE = 30;
	localparam int unsigned MIX_SH_TWO = 27;
	localparam int unsigned MIX_SH_OUT = 31;

	localparam int unsigned ROT_SUM    = 23;
	localparam int unsigned SHIFT_T    = 17;
	localparam int unsigned ROT_D      = 45;
	localparam int unsigned FRAC_SHIFT = 11;

	// Five splitmix64 outputs per seed: trajectory seed, then words a to d.
	localparam int unsigned STEP_W = 3;
	localparam logic [STEP_W-1:0] STEP_FIRST = 3'd0;
	localparam logic [STEP_W-1:0] STEP_LAST  = 3'd4;

	typedef enum logic {
		CMD_SEED = 1'b0,
		CMD_DRAW = 1'b1
	} cmd_code_t;

	typedef struct packed {
		cmd_code_t               code;
		logic [TRAJ_INC_W-1:0]   traj_inc;
	} cmd_t;

	typedef struct packed {
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		logic [WORD_W-1:0] c;
		logic [WORD_W-1:0] d;
	} lane_state_t;

	typedef struct packed {
		logic              start;
		logic [WORD_W-1:0] op_a;
		logic [WORD_W-1:0] op_b;
	} mul_req_t;

	typedef struct packed {
		logic              done;
		logic [WORD_W-1:0] product;
	} mul_rsp_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DRAW,
		BK_TRAJ,
		BK_MIX_ADD,
		BK_MIX_M1,
		BK_MIX_M2,
		BK_SEED_WR
	} bk_state_t;

endpackage
`default_nettype wire

>>> design/xlg_cmd_if.sv
// Request channel interface: command, lane and trajectory number.
`default_nettype none
interface xlg_cmd_if;
	logic                             valid;
	logic                             ready;
	logic                             command;
	logic [xlg_pkg::LANE_IN_W-1:0]    lane;
	logic [xlg_pkg::TRAJ_IN_W-1:0]    trajectory_number;

	modport source (output valid, command, lane, trajectory_number, input ready);
	modport sink   (input valid, command, lane, trajectory_number, output ready);
endinterface
`default_nettype wire

>>> design/xlg_res_if.sv
// Result channel interface: random word and unit fraction.
`default_nettype none
interface xlg_res_if;
	logic                          valid;
	logic                          ready;
	logic [xlg_pkg::WORD_W-1:0]    random_word;
	logic [xlg_pkg::FRAC_W-1:0]    unit_fraction;

	modport source (output valid, random_word, unit_fraction, input ready);
	modport sink   (input valid, random_word, unit_fraction, output ready);
endinterface
`default_nettype wire

>>> design/xlg_cfg_if.sv
// Configuration write channel interface carrying the run seed.
`default_nettype none
interface xlg_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [xlg_pkg::WORD_W-1:0]    run_seed;

	modport source (output valid, run_seed, input ready);
	modport sink   (input valid, run_seed, output ready);
endinterface
`default_nettype wire

>>> design/xlg_front.sv
// Front end: accepts requests, wraps the lane index and queues commands for the back end.
`default_nettype none
module xlg_front #(
	parameter  int unsigned LANE_COUNT = xlg_pkg::LANE_COUNT_DEF,
	localparam int unsigned LANE_W     = (LANE_COUNT > 1) ? $clog2(LANE_COUNT) : 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	xlg_cmd_if.sink                req,
	output logic                   head_valid,
	output xlg_pkg::cmd_t          head,
	output logic [LANE_W-1:0]      head_lane,
	input  wire logic              pop
);

	logic [LANE_W-1:0] wrap_tab [xlg_pkg::LANE_SPAN];

	// Lane numbers beyond the bank fold back modulo the lane count.
	for (genvar g = 0; g < xlg_pkg::LANE_SPAN; g++) begin : g_wrap
		localparam int unsigned WRAPPED = g % LANE_COUNT;
		assign wrap_tab[g] = LANE_W'(WRAPPED);
	end

	xlg_pkg::cmd_t                  q_cmd  [xlg_pkg::QUEUE_DEPTH];
	logic [LANE_W-1:0]              q_lane [xlg_pkg::QUEUE_DEPTH];
	logic [xlg_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [xlg_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [xlg_pkg::QPTR_W:0]       count_q;
	logic                           push;
	xlg_pkg::cmd_t                  push_cmd;

	assign req.ready  = (count_q != (xlg_pkg::QPTR_W + 1)'(xlg_pkg::QUEUE_DEPTH));
	assign push       = req.valid && req.ready;
	assign head_valid = (count_q != '0);
	assign head       = q_cmd[rd_ptr_q];
	assign head_lane  = q_lane[rd_ptr_q];

	always_comb begin
		push_cmd.code     = req.command ? xlg_pkg::CMD_DRAW : xlg_pkg::CMD_SEED;
		push_cmd.traj_inc = {1'b0, req.trajectory_number} + xlg_pkg::TRAJ_INC_W'(1);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_cmd[wr_ptr_q]  <= push_cmd;
			q_lane[wr_ptr_q] <= wrap_tab[req.lane];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + xlg_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + xlg_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (xlg_pkg::QPTR_W + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (xlg_pkg::QPTR_W + 1)'(1);
			end
		end
	end

endmodule
`default_nettype wire

>>> design/xlg_mul64.sv
// Iterative 64x64 multiplier, low 64 bits of the product, from three 32x32 partial products.
`default_nettype none
module xlg_mul64 (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire xlg_pkg::mul_req_t mreq,
	output xlg_pkg::mul_rsp_t      mrsp
);

	localparam int unsigned HW = xlg_pkg::HALF_W;
	localparam int unsigned WW = xlg_pkg::WORD_W;

	logic [WW-1:0] a_q;
	logic [WW-1:0] b_q;
	logic [WW-1:0] prod_q;
	logic [WW-1:0] acc_q;
	logic [1:0]    phase_q;
	logic          busy_q;
	logic          done_q;
	logic [HW-1:0] op_x;
	logic [HW-1:0] op_y;
	logic [WW-1:0] prod_d;

	// Phase 0 takes lo*lo, phases 1 and 2 the cross terms; the sum adds registered products.
	always_comb begin
		case (phase_q)
			2'd0: begin
				op_x = a_q[HW-1:0];
				op_y = b_q[HW-1:0];
			end
			2'd1: begin
				op_x = a_q[HW-1:0];
				op_y = b_q[WW-1:HW];
			end
			2'd2: begin
				op_x = a_q[WW-1:HW];
				op_y = b_q[HW-1:0];
			end
			default: begin
				op_x = '0;
				op_y = '0;
			end
		endcase
	end

	assign prod_d = WW'(op_x) * WW'(op_y);

	always_ff @(posedge clk) begin
		if (mreq.start) begin
			a_q <= mreq.op_a;
			b_q <= mreq.op_b;
		end else if (busy_q) begin
			prod_q <= prod_d;
			case (phase_q)
				2'd1: begin
					acc_q <= prod_q;
				end
				2'd2, 2'd3: begin
					acc_q[WW-1:HW] <= acc_q[WW-1:HW] + prod_q[HW-1:0];
				end
				default: begin
					acc_q <= acc_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (mreq.start) begin
				phase_q <= '0;
				busy_q  <= 1'b1;
			end else if (busy_q) begin
				phase_q <= phase_q + 2'd1;
				if (phase_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign mrsp.done    = done_q;
	assign mrsp.product = acc_q;

endmodule
`default_nettype wire

>>> design/xlg_back.sv
// Back end: lane state memory, xoshiro256++ draw step, splitmix64 seeding sequencer, result register.
`default_nettype none
module xlg_back #(
	parameter  int unsigned LANE_COUNT = xlg_pkg::LANE_COUNT_DEF,
	localparam int unsigned LANE_W     = (LANE_COUNT > 1) ? $clog2(LANE_COUNT) : 1
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [xlg_pkg::WORD_W-1:0]  run_seed,
	input  wire logic                        head_valid,
	input  wire xlg_pkg::cmd_t               head,
	input  wire logic [LANE_W-1:0]           head_lane,
	output logic                             pop,
	output xlg_pkg::mul_req_t                mreq,
	input  wire xlg_pkg::mul_rsp_t           mrsp,
	xlg_res_if.source                        rsp
);

	localparam int unsigned WW = xlg_pkg::WORD_W;

	function automatic logic [WW-1:0] rotl(input logic [WW-1:0] v, input int unsigned amt);
		return (v << amt) | (v >> (WW - amt));
	endfunction

	xlg_pkg::lane_state_t           mem [LANE_COUNT];
	xlg_pkg::lane_state_t           rd_q;
	xlg_pkg::bk_state_t             state_q;
	xlg_pkg::bk_state_t             state_d;
	logic [LANE_W-1:0]              lane_q;
	logic [xlg_pkg::STEP_W-1:0]     step_q;
	logic [WW-1:0]                  walk_q;
	logic [WW-1:0]                  tseed_q;
	logic [WW-1:0]                  seed_q [4];
	logic [WW-1:0]                  out_word_q;
	logic [xlg_pkg::FRAC_W-1:0]     out_frac_q;
	logic                           out_valid_q;
	logic                           slot_free;

	logic                           rd_en;
	logic                           mem_we;
	logic                           out_load;
	xlg_pkg::lane_state_t           wdata;
	logic [WW-1:0]                  ld_word;
	logic [xlg_pkg::FRAC_W-1:0]     ld_frac;

	logic [WW-1:0]                  walk_next;
	logic [WW-1:0]                  mix_out;
	logic [WW-1:0]                  draw_word;
	xlg_pkg::lane_state_t           draw_next;
	logic [WW-1:0]                  t_val;
	logic [WW-1:0]                  c_one;
	logic [WW-1:0]                  d_one;
	logic [1:0]                     seed_idx;

	assign slot_free = !out_valid_q || rsp.ready;
	assign walk_next = walk_q + xlg_pkg::GOLDEN_GAMMA;
	assign mix_out   = mrsp.product ^ (mrsp.product >> xlg_pkg::MIX_SH_OUT);
	assign seed_idx  = 2'(step_q - xlg_pkg::STEP_W'(1));

	// One xoshiro256++ step on the state read from the lane memory.
	always_comb begin
		draw_word   = rotl(rd_q.a + rd_q.d, xlg_pkg::ROT_SUM) + rd_q.a;
		t_val       = rd_q.b << xlg_pkg::SHIFT_T;
		c_one       = rd_q.c ^ rd_q.a;
		d_one       = rd_q.d ^ rd_q.b;
		draw_next.b = rd_q.b ^ c_one;
		draw_next.a = rd_q.a ^ d_one;
		draw_next.c = c_one ^ t_val;
		draw_next.d = rotl(d_one, xlg_pkg::ROT_D);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			xlg_pkg::BK_IDLE: begin
				if (head_valid) begin
					state_d = (head.code == xlg_pkg::CMD_DRAW) ? xlg_pkg::BK_DRAW
						: xlg_pkg::BK_TRAJ;
				end
			end
			xlg_pkg::BK_DRAW: begin
				if (slot_free) begin
					state_d = xlg_pkg::BK_IDLE;
				end
			end
			xlg_pkg::BK_TRAJ: begin
				if (mrsp.done) begin
					state_d = xlg_pkg::BK_MIX_ADD;
				end
			end
			xlg_pkg::BK_MIX_ADD: begin
				state_d = xlg_pkg::BK_MIX_M1;
			end
			xlg_pkg::BK_MIX_M1: begin
				if (mrsp.done) begin
					state_d = xlg_pkg::BK_MIX_M2;
				end
			end
			xlg_pkg::BK_MIX_M2: begin
				if (mrsp.done) begin
					state_d = (step_q == xlg_pkg::STEP_LAST) ? xlg_pkg::BK_SEED_WR
						: xlg_pkg::BK_MIX_ADD;
				end
			end
			xlg_pkg::BK_SEED_WR: begin
				if (slot_free) begin
					state_d = xlg_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = xlg_pkg::BK_IDLE;
			end
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		rd_en     = 1'b0;
		mem_we    = 1'b0;
		out_load  = 1'b0;
		mreq      = '0;
		wdata     = draw_next;
		ld_word   = draw_word;
		ld_frac   = {draw_word[WW-1:xlg_pkg::FRAC_SHIFT], 1'b1};
		case (state_q)
			xlg_pkg::BK_IDLE: begin
				pop   = head_valid;
				rd_en = head_valid;
				if (head_valid && head.code == xlg_pkg::CMD_SEED) begin
					mreq.start = 1'b1;
					mreq.op_a  = xlg_pkg::TRAJ_MUL;
					mreq.op_b  = WW'(head.traj_inc);
				end
			end
			xlg_pkg::BK_DRAW: begin
				mem_we   = slot_free;
				out_load = slot_free;
			end
			xlg_pkg::BK_MIX_ADD: begin
				mreq.start = 1'b1;
				mreq.op_a  = walk_next ^ (walk_next >> xlg_pkg::MIX_SH_ONE);
				mreq.op_b  = xlg_pkg::MIX_MUL_ONE;
			end
			xlg_pkg::BK_MIX_M1: begin
				mreq.start = mrsp.done;
				mreq.op_a  = mrsp.product ^ (mrsp.product >> xlg_pkg::MIX_SH_TWO);
				mreq.op_b  = xlg_pkg::MIX_MUL_TWO;
			end
			xlg_pkg::BK_SEED_WR: begin
				mem_we   = slot_free;
				out_load = slot_free;
				wdata    = '{a: seed_q[0], b: seed_q[1], c: seed_q[2], d: seed_q[3]};
				ld_word  = tseed_q;
				ld_frac  = '0;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[lane_q] <= wdata;
		end
		if (rd_en) begin
			rd_q <= mem[head_lane];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			lane_q <= head_lane;
		end
		if (state_q == xlg_pkg::BK_TRAJ && mrsp.done) begin
			walk_q <= run_seed ^ mrsp.product;
		end else if (state_q == xlg_pkg::BK_MIX_ADD) begin
			walk_q <= walk_next;
		end else if (state_q == xlg_pkg::BK_MIX_M2 && mrsp.done
			&& step_q == xlg_pkg::STEP_FIRST) begin
			// The lane words continue the splitmix64 walk from the trajectory seed.
			walk_q <= mix_out;
		end
		if (state_q == xlg_pkg::BK_MIX_M2 && mrsp.done) begin
			if (step_q == xlg_pkg::STEP_FIRST) begin
				tseed_q <= mix_out;
			end else begin
				seed_q[seed_idx] <= mix_out;
			end
		end
		if (out_load) begin
			out_word_q <= ld_word;
			out_frac_q <= ld_frac;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= xlg_pkg::BK_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				step_q <= xlg_pkg::STEP_FIRST;
			end else if (state_q == xlg_pkg::BK_MIX_M2 && mrsp.done) begin
				step_q <= step_q + xlg_pkg::STEP_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.random_word   = out_word_q;
	assign rsp.unit_fraction = out_frac_q;

endmodule
`default_nettype wire

>>> design/xoshiro256pp_lane_generator.sv
// Top level: base seed register, request queue, shared multiplier and lane generator back end.
// A draw passes the queue, the registered lane state read and the result register. A draw ends
// with its write-back, held while the result slot is full, before the next is taken. A seed
// holds the back end for eleven 64-bit products on the shared 32x32 multiplier, five splitmix64
// add steps, plus issue and write-back. A 4-entry queue takes requests meanwhile until full.
// Reset clears queue, sequencer, multiplier control, result valid and base seed only.
`default_nettype none
module xoshiro256pp_lane_generator #(
	parameter int unsigned LANE_COUNT = xlg_pkg::LANE_COUNT_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	xlg_cmd_if.sink      req,
	xlg_res_if.source    rsp,
	xlg_cfg_if.sink      cfg
);

	localparam int unsigned LANE_W = (LANE_COUNT > 1) ? $clog2(LANE_COUNT) : 1;

	logic [xlg_pkg::WORD_W-1:0] run_seed_q;
	logic                       head_valid;
	xlg_pkg::cmd_t              head;
	logic [LANE_W-1:0]          head_lane;
	logic                       pop;
	xlg_pkg::mul_req_t          mreq;
	xlg_pkg::mul_rsp_t          mrsp;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_seed_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			run_seed_q <= cfg.run_seed;
		end
	end

	xlg_front #(
		.LANE_COUNT (LANE_COUNT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.head_valid (head_valid),
		.head       (head),
		.head_lane  (head_lane),
		.pop        (pop)
	);

	xlg_mul64 u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.mreq   (mreq),
		.mrsp   (mrsp)
	);

	xlg_back #(
		.LANE_COUNT (LANE_COUNT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.run_seed   (run_seed_q),
		.head_valid (head_valid),
		.head       (head),
		.head_lane  (head_lane),
		.pop        (pop),
		.mreq       (mreq),
		.mrsp       (mrsp),
		.rsp        (rsp)
	);

endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench of the xoshiro256++ lane generator with a bit-exact bank predictor.
`timescale 1ns / 1ps

module testbench;

	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned RANDOM_PER_PHASE = 500;

	typedef struct {
		logic [xlg_pkg::WORD_W-1:0] word;
		logic [xlg_pkg::FRAC_W-1:0] frac;
	} lane_output_t;

	// Mirrors the generator bank and holds the outputs still owed by the block.
	class xoshiro_bank_checker;
		logic [xlg_pkg::WORD_W-1:0] run_seed;
		logic [xlg_pkg::WORD_W-1:0] gen_a [xlg_pkg::LANE_SPAN];
		logic [xlg_pkg::WORD_W-1:0] gen_b [xlg_pkg::LANE_SPAN];
		logic [xlg_pkg::WORD_W-1:0] gen_c [xlg_pkg::LANE_SPAN];
		logic [xlg_pkg::WORD_W-1:0] gen_d [xlg_pkg::LANE_SPAN];
		lane_output_t awaited_outputs [$];
		int unsigned mismatches;

		function new();
			run_seed = '0;
			mismatches = 0;
		endfunction

		function logic [xlg_pkg::WORD_W-1:0] splitmix_next(
				inout logic [xlg_pkg::WORD_W-1:0] counter);
			logic [xlg_pkg::WORD_W-1:0] z;
			counter = counter + xlg_pkg::GOLDEN_GAMMA;
			z = counter;
			z = (z ^ (z >> xlg_pkg::MIX_SH_ONE)) * xlg_pkg::MIX_MUL_ONE;
			z = (z ^ (z >> xlg_pkg::MIX_SH_TWO)) * xlg_pkg::MIX_MUL_TWO;
			return z ^ (z >> xlg_pkg::MIX_SH_OUT);
		endfunction

		function logic [xlg_pkg::WORD_W-1:0] rotl(logic [xlg_pkg::WORD_W-1:0] v, int unsigned n);
			return (v << n) | (v >> (xlg_pkg::WORD_W - n));
		endfunction

		function void note_request(xlg_pkg::cmd_code_t cmd, logic [xlg_pkg::LANE_IN_W-1:0] lane,
				logic [xlg_pkg::TRAJ_IN_W-1:0] traj);
			logic [xlg_pkg::WORD_W-1:0] counter, walk, a, b, c, d, t;
			lane_output_t out;
			if (cmd == xlg_pkg::CMD_SEED) begin
				counter = run_seed ^ (xlg_pkg::TRAJ_MUL
					* ({{(xlg_pkg::WORD_W-xlg_pkg::TRAJ_IN_W){1'b0}}, traj} + 64'd1));
				out.word = splitmix_next(counter);
				out.frac = '0;
				walk = out.word;
				gen_a[lane] = splitmix_next(walk);
				gen_b[lane] = splitmix_next(walk);
				gen_c[lane] = splitmix_next(walk);
				gen_d[lane] = splitmix_next(walk);
			end else begin
				a = gen_a[lane];
				b = gen_b[lane];
				c = gen_c[lane];
				d = gen_d[lane];
				out.word = rotl(a + d, xlg_pkg::ROT_SUM) + a;
				out.frac = {out.word[xlg_pkg::WORD_W-1:xlg_pkg::FRAC_SHIFT], 1'b1};
				t = b << xlg_pkg::SHIFT_T;
				c ^= a;
				d ^= b;
				b ^= c;
				a ^= d;
				c ^= t;
				gen_a[lane] = a;
				gen_b[lane] = b;
				gen_c[lane] = c;
				gen_d[lane] = rotl(d, xlg_pkg::ROT_D);
			end
			awaited_outputs.insert(awaited_outputs.size(), out);
		endfunction

		function void check_output(logic [xlg_pkg::WORD_W-1:0] word,
				logic [xlg_pkg::FRAC_W-1:0] frac);
			lane_output_t want;
			if (awaited_outputs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with none pending: word %h frac %h", $realtime, word, frac);
				return;
			end
			want = awaited_outputs.pop_front();
			if (word !== want.word || frac !== want.frac) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: mismatch: word %h (want %h) frac %h (want %h)",
						$realtime, word, want.word, frac, want.frac);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	xlg_cmd_if req_ch ();
	xlg_res_if rsp_ch ();
	xlg_cfg_if cfg_ch ();

	xoshiro256pp_lane_generator uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	xoshiro_bank_checker bank = new();
	bit lane_seeded [xlg_pkg::LANE_SPAN];
	int unsigned burst_left;
	int unsigned stall_cycles = 0;

	always #5 clk = ~clk;

	task automatic pace();
		int unsigned gap;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			repeat (gap) begin
				@(negedge clk);
				req_ch.valid <= 1'b0;
			end
		end
	endtask

	task automatic send_request(xlg_pkg::cmd_code_t cmd, logic [xlg_pkg::LANE_IN_W-1:0] lane,
			logic [xlg_pkg::TRAJ_IN_W-1:0] traj);
		@(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.command <= cmd;
		req_ch.lane <= lane;
		req_ch.trajectory_number <= traj;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		bank.note_request(cmd, lane, traj);
		if (cmd == xlg_pkg::CMD_SEED)
			lane_seeded[lane] = 1'b1;
		pace();
	endtask

	task automatic wait_for_drain();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (bank.awaited_outputs.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_run_seed(logic [xlg_pkg::WORD_W-1:0] value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.run_seed <= value;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		bank.run_seed = value;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic random_request();
		logic [xlg_pkg::LANE_IN_W-1:0] lane;
		logic [63:0] bits;
		logic [xlg_pkg::TRAJ_IN_W-1:0] traj;
		xlg_pkg::cmd_code_t cmd;
		lane = xlg_pkg::LANE_IN_W'($urandom_range(0, xlg_pkg::LANE_SPAN - 1));
		bits = {$urandom(), $urandom()};
		case ($urandom_range(0, 9))
			0: traj = '0;
			1: traj = '1;
			default: traj = bits[xlg_pkg::TRAJ_IN_W-1:0];
		endcase
		// A lane must hold a seed before it may be drawn from.
		cmd = (!lane_seeded[lane] || $urandom_range(0, 9) == 0) ? xlg_pkg::CMD_SEED
			: xlg_pkg::CMD_DRAW;
		send_request(cmd, lane, traj);
	endtask

	// Seeds both ends of lane and trajectory ranges, draws from each, then seeds lanes 1 to 14.
	task automatic directed_requests();
		send_request(xlg_pkg::CMD_SEED, 4'd0, '0);
		send_request(xlg_pkg::CMD_SEED, 4'd15, '1);
		repeat (3) send_request(xlg_pkg::CMD_DRAW, 4'd0, '0);
		repeat (3) send_request(xlg_pkg::CMD_DRAW, 4'd15, '1);
		for (int i = 1; i < 15; i++)
			send_request(xlg_pkg::CMD_SEED, xlg_pkg::LANE_IN_W'(i),
				i[0] ? 35'h5_5555_5555 : 35'h2_AAAA_AAAA);
		send_request(xlg_pkg::CMD_DRAW, 4'd7, '1);
		send_request(xlg_pkg::CMD_DRAW, 4'd8, '0);
	endtask

	// The receiver switches at random between several stall patterns.
	initial begin
		int unsigned mode;
		int unsigned tick;
		mode = 0;
		tick = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (tick % 64 == 0)
				mode = $urandom_range(0, 4);
			case (mode)
				0: rsp_ch.ready <= 1'b1;
				1: rsp_ch.ready <= 1'($urandom_range(0, 1));
				2: rsp_ch.ready <= (tick % 8 != 0);
				3: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
				default: rsp_ch.ready <= (tick % 32 == 0);
			endcase
			tick++;
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
			bank.check_output(rsp_ch.random_word, rsp_ch.unit_fraction);
		if ((req_ch.valid && req_ch.ready) === 1'b1 || (rsp_ch.valid && rsp_ch.ready) === 1'b1
				|| (cfg_ch.valid && cfg_ch.ready) === 1'b1)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	initial begin
		logic [xlg_pkg::WORD_W-1:0] phase_seed [4];
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.command = xlg_pkg::CMD_SEED;
		req_ch.lane = '0;
		req_ch.trajectory_number = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.run_seed = '0;
		burst_left = 0;
		phase_seed[0] = '0;
		phase_seed[1] = '1;
		phase_seed[2] = {$urandom(), $urandom()};
		phase_seed[3] = {$urandom(), $urandom()};
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		for (int p = 0; p < 4; p++) begin
			if (p > 0) begin
				wait_for_drain();
				repeat (8) @(negedge clk);
			end
			write_run_seed(phase_seed[p]);
			if (p == 0)
				directed_requests();
			for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
				random_request();
				// Let the block run completely dry once in the middle of a phase.
				if (p == 1 && i == RANDOM_PER_PHASE / 2)
					wait_for_drain();
			end
		end

		wait_for_drain();
		repeat (20) @(posedge clk);
		if (bank.mismatches == 0 && bank.awaited_outputs.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
